@@ hw/rtl/rpvg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the radial polynomial vignette gain block.
// No dependencies; imported by rpvg_regs and radial_polynomial_vignette_gain.
package rpvg_pkg;

	localparam int MAX_TERMS_DEF = 4;
	localparam int NUM_COEF      = 4;
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 32;

	// Q16.16 unity gain.
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	typedef enum logic [2:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_VSCALE     = 3'd2,
		REG_TERM_COUNT = 3'd3,
		REG_COEF_ZERO  = 3'd4,
		REG_COEF_ONE   = 3'd5,
		REG_COEF_TWO   = 3'd6,
		REG_COEF_THREE = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_COEF-1:0][31:0] coef;        // signed Q16.16 each
		logic [2:0]                term_count;
		logic [15:0]               vertical_scale;  // unsigned Q4.12
		logic [15:0]               center_y;        // signed Q3.12
		logic [15:0]               center_x;        // signed Q3.12
	} cfg_t;

endpackage

@@ hw/rtl/radial_polynomial_vignette_gain.sv @@
`timescale 1ns / 1ps
// Top level: 12-stage pipeline computing a radial polynomial vignetting gain.
// Depends on rpvg_pkg and rpvg_regs.
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  ----------------------------------------
//  s_*       in   s_tvalid/s_tready  s_tdata: point_x[15:0], point_y[31:16]
//  m_*       out  m_tvalid/m_tready  m_tdata: gain[31:0]
//  APB       in   psel/penable       register i at byte address 4*i
//
// One point per clock sustained while m_tready does not stall the output; a point
// accepted into stage 1 moves through the stages in order and leaves from stage 12.
// The latency is set by the dependent multiplies r2 -> r2^2 -> r2^3 -> c3*r2^3,
// each 32x32 product followed by its own rounding stage.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse; a stall on m_tready holds each loaded stage between the output and the nearest bubble.
// arst_n clears the valid bits and loads the register reset values.
module radial_polynomial_vignette_gain #(
	parameter int MAX_TERMS = rpvg_pkg::MAX_TERMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// point input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,   // point_x[15:0], point_y[31:16]
	// gain output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,   // gain[31:0]
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rpvg_pkg::ADDR_W-1:0] paddr,
	input  logic [rpvg_pkg::DATA_W-1:0] pwdata,
	output logic [rpvg_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import rpvg_pkg::*;

	localparam int NSTG = 12;

	// Magnitude of a signed 32-bit word; the most negative value maps to 2^31.
	function automatic logic [31:0] mag32(input logic [31:0] v);
		logic [31:0] r;
		r = v[31] ? (~v + 32'd1) : v;
		return r;
	endfunction

	// Round a 64-bit Q.32 product half up to Q.16.
	function automatic logic [48:0] rnd16(input logic [63:0] v);
		logic [64:0] s;
		s = {1'b0, v} + 65'd32768;
		return s[64:16];
	endfunction

	// Clamp an unsigned 49-bit value to 32 bits.
	function automatic logic [31:0] sat32u(input logic [48:0] v);
		logic [31:0] r;
		r = (v[48:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
		return r;
	endfunction

	// Signed contribution of one term, zero when the term is not active.
	function automatic logic signed [50:0] term(input logic en, input logic neg,
						    input logic [48:0] mag);
		logic signed [50:0] r;
		r = $signed({2'b00, mag});
		if (!en)
			r = '0;
		else if (neg)
			r = -r;
		return r;
	endfunction

	cfg_t cfg;

	rpvg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Active term count, clamped to MAX_TERMS. Config must only change while idle; the block does not enforce this.
	logic [2:0]          n_eff;
	logic [NUM_COEF-1:0] term_en;
	logic [NUM_COEF-1:0][31:0] cmag;

	assign n_eff = (cfg.term_count > 3'(MAX_TERMS)) ? 3'(MAX_TERMS) : cfg.term_count;

	always_comb begin
		for (int k = 0; k < NUM_COEF; k++) begin
			term_en[k] = (3'(k) < n_eff);
			cmag[k]    = mag32(cfg.coef[k]);
		end
	end

	// Stage valids and advance enables; en[k] means stage k loads this cycle.
	logic [NSTG:1]   vld_q;
	logic [NSTG:1]   en;
	logic [NSTG-1:0] vin;

	always_comb begin
		en[NSTG] = !vld_q[NSTG] || m_tready;
		for (int k = NSTG - 1; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
		vin[0] = s_tvalid;
		for (int k = 1; k < NSTG; k++)
			vin[k] = vld_q[k];
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++)
				if (en[k])
					vld_q[k] <= vin[k-1];
		end
	end

	// Stage 1: offsets from the centre, as magnitudes.
	logic signed [16:0] dx_diff, dy_diff;
	logic [15:0] dx_s1, dyu_s1;

	assign dx_diff = $signed({s_tdata[15], s_tdata[15:0]})
		       - $signed({cfg.center_x[15], cfg.center_x});
	assign dy_diff = $signed({s_tdata[31], s_tdata[31:16]})
		       - $signed({cfg.center_y[15], cfg.center_y});

	always_ff @(posedge clk) begin
		if (en[1] && vin[0]) begin
			dx_s1  <= dx_diff[16]  ? 16'(-dx_diff)  : dx_diff[15:0];
			dyu_s1 <= dy_diff[16]  ? 16'(-dy_diff)  : dy_diff[15:0];
		end
	end

	// Stage 2: dx squared and the vertical offset scaled into Q.24.
	logic [31:0] dx2_s2, dyq_s2;

	always_ff @(posedge clk) begin
		if (en[2] && vin[1]) begin
			dx2_s2 <= 32'(dx_s1) * 32'(dx_s1);
			dyq_s2 <= 32'(dyu_s1) * 32'(cfg.vertical_scale);
		end
	end

	// Stage 3: round the scaled vertical offset back to Q.12.
	logic [32:0] dyq_rnd;
	logic [19:0] dy_s3;
	logic [31:0] dx2_s3;

	assign dyq_rnd = {1'b0, dyq_s2} + 33'd2048;

	always_ff @(posedge clk) begin
		if (en[3] && vin[2]) begin
			dy_s3  <= dyq_rnd[31:12];
			dx2_s3 <= dx2_s2;
		end
	end

	// Stage 4: dy squared.
	logic [39:0] dy2_s4;
	logic [31:0] dx2_s4;

	always_ff @(posedge clk) begin
		if (en[4] && vin[3]) begin
			dy2_s4 <= 40'(dy_s3) * 40'(dy_s3);
			dx2_s4 <= dx2_s3;
		end
	end

	// Stage 5: r2 in Q16.16, rounded half up and saturated.
	logic [40:0] r2_sum;
	logic [31:0] r2_s5;

	assign r2_sum = 41'(dx2_s4) + 41'(dy2_s4) + 41'd128;

	always_ff @(posedge clk) begin
		if (en[5] && vin[4])
			r2_s5 <= r2_sum[40] ? 32'hFFFF_FFFF : r2_sum[39:8];
	end

	// Stage 6: r2^2 raw and coef one times r2 raw.
	logic [63:0] pp2_s6, mt1_s6;
	logic [31:0] r2_s6;

	always_ff @(posedge clk) begin
		if (en[6] && vin[5]) begin
			pp2_s6 <= 64'(r2_s5) * 64'(r2_s5);
			mt1_s6 <= 64'(cmag[1]) * 64'(r2_s5);
			r2_s6  <= r2_s5;
		end
	end

	// Stage 7: round r2^2 and term one.
	logic [31:0] p2_s7, r2_s7;
	logic [48:0] t1_s7;

	always_ff @(posedge clk) begin
		if (en[7] && vin[6]) begin
			p2_s7 <= sat32u(rnd16(pp2_s6));
			t1_s7 <= rnd16(mt1_s6);
			r2_s7 <= r2_s6;
		end
	end

	// Stage 8: r2^3 raw and coef two times r2^2 raw.
	logic [63:0] pp3_s8, mt2_s8;
	logic [48:0] t1_s8;

	always_ff @(posedge clk) begin
		if (en[8] && vin[7]) begin
			pp3_s8 <= 64'(p2_s7) * 64'(r2_s7);
			mt2_s8 <= 64'(cmag[2]) * 64'(p2_s7);
			t1_s8  <= t1_s7;
		end
	end

	// Stage 9: round r2^3 and term two.
	logic [31:0] p3_s9;
	logic [48:0] t1_s9, t2_s9;

	always_ff @(posedge clk) begin
		if (en[9] && vin[8]) begin
			p3_s9 <= sat32u(rnd16(pp3_s8));
			t2_s9 <= rnd16(mt2_s8);
			t1_s9 <= t1_s8;
		end
	end

	// Stage 10: coef three times r2^3 raw.
	logic [63:0] mt3_s10;
	logic [48:0] t1_s10, t2_s10;

	always_ff @(posedge clk) begin
		if (en[10] && vin[9]) begin
			mt3_s10 <= 64'(cmag[3]) * 64'(p3_s9);
			t1_s10  <= t1_s9;
			t2_s10  <= t2_s9;
		end
	end

	// Stage 11: round term three.
	logic [48:0] t1_s11, t2_s11, t3_s11;

	always_ff @(posedge clk) begin
		if (en[11] && vin[10]) begin
			t3_s11 <= rnd16(mt3_s10);
			t1_s11 <= t1_s10;
			t2_s11 <= t2_s10;
		end
	end

	// Stage 12: signed sum of the active terms, saturate; unity with no terms.
	// Term zero is the coefficient itself since r2^0 is exactly 1.0.
	logic signed [50:0] acc;
	logic [31:0]        gain_sat;
	logic [31:0]        gain_s12;

	always_comb begin
		acc = term(term_en[0], cfg.coef[0][31], {17'd0, cmag[0]})
		    + term(term_en[1], cfg.coef[1][31], t1_s11)
		    + term(term_en[2], cfg.coef[2][31], t2_s11)
		    + term(term_en[3], cfg.coef[3][31], t3_s11);
		if (n_eff == 3'd0)
			gain_sat = ONE_Q16;
		else if (acc > 51'sd2147483647)
			gain_sat = 32'h7FFF_FFFF;
		else if (acc < -51'sd2147483648)
			gain_sat = 32'h8000_0000;
		else
			gain_sat = acc[31:0];
	end

	always_ff @(posedge clk) begin
		if (en[12] && vin[11])
			gain_s12 <= gain_sat;
	end

	assign m_tdata = gain_s12;

endmodule

@@ hw/rtl/rpvg_regs.sv @@
`timescale 1ns / 1ps
// APB register file holding centre, scale, term count and coefficients.
// Depends on rpvg_pkg for the register map and the cfg_t struct.
module rpvg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rpvg_pkg::ADDR_W-1:0] paddr,
	input  logic [rpvg_pkg::DATA_W-1:0] pwdata,
	output logic [rpvg_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output rpvg_pkg::cfg_t              cfg
);
	import rpvg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x       <= '0;
			cfg_q.center_y       <= '0;
			cfg_q.vertical_scale <= 16'd4096;
			cfg_q.term_count     <= '0;
			cfg_q.coef           <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_CENTER_X:   cfg_q.center_x       <= pwdata[15:0];
				REG_CENTER_Y:   cfg_q.center_y       <= pwdata[15:0];
				REG_VSCALE:     cfg_q.vertical_scale <= pwdata[15:0];
				REG_TERM_COUNT: cfg_q.term_count     <= pwdata[2:0];
				REG_COEF_ZERO:  cfg_q.coef[0]        <= pwdata;
				REG_COEF_ONE:   cfg_q.coef[1]        <= pwdata;
				REG_COEF_TWO:   cfg_q.coef[2]        <= pwdata;
				REG_COEF_THREE: cfg_q.coef[3]        <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CENTER_X:   prdata = {16'd0, cfg_q.center_x};
			REG_CENTER_Y:   prdata = {16'd0, cfg_q.center_y};
			REG_VSCALE:     prdata = {16'd0, cfg_q.vertical_scale};
			REG_TERM_COUNT: prdata = {29'd0, cfg_q.term_count};
			REG_COEF_ZERO:  prdata = cfg_q.coef[0];
			REG_COEF_ONE:   prdata = cfg_q.coef[1];
			REG_COEF_TWO:   prdata = cfg_q.coef[2];
			REG_COEF_THREE: prdata = cfg_q.coef[3];
			default:        prdata = '0;
		endcase
	end

endmodule
